// File: src/lap5n_pkg.sv
// Shared types and constants for the five-point Laplacian stream core.
// No dependencies; every other file in src except lap5n_ram imports this package.
`timescale 1ns / 1ps
`default_nettype none

package lap5n_pkg;

   // payload widths
   localparam int SAMPLE_W    = 24;  // signed Q8.16 grid sample
   localparam int COEF_W      = 32;  // unsigned Q16.16 coefficient
   localparam int CFG_SIZE_W  = 11;  // grid_width / grid_height register width
   localparam int RESULT_W    = 48;  // signed Q32.16 result
   localparam int FRAC_BITS   = 16;

   // l - 2c + r over 24-bit samples needs two more bits
   localparam int DIFF_W = SAMPLE_W + 2;
   // signed diff times zero-extended coefficient
   localparam int PROD_W = DIFF_W + COEF_W + 1;
   // sum of both products, wide enough that the top result bit is a select
   localparam int SUM_W  = RESULT_W + FRAC_BITS;

   localparam int GRID_MIN = 2;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = COEF_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_X      = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_Y      = 2'd3;

   localparam logic [CFG_SIZE_W-1:0] GRID_SIZE_RESET = 11'd64;
   localparam logic [COEF_W-1:0]     COEF_RESET      = 32'd65536;

   // request opcodes
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_DRAIN  = 1'b1;

   // where the result point sits in the grid, decided at acceptance
   typedef struct packed {
      logic emit;       // this transaction produces a result
      logic col_first;  // result column is 0: mirror left from right
      logic col_last;   // result column is width-1: mirror right from left
      logic row_first;  // result row is 0: mirror up from down
      logic row_last;   // result row is height-1: mirror down from up
   } point_flags_type;

endpackage

`default_nettype wire

// File: src/lap5n_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lap5n_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     write_en,
   input  wire logic [$clog2(DEPTH)-1:0] write_addr,
   input  wire logic [WIDTH-1:0]         write_data,
   input  wire logic                     read_en,
   input  wire logic [$clog2(DEPTH)-1:0] read_addr,
   output      logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[write_addr] <= write_data;
      end
      if (read_en) begin
         read_data_ff <= mem_ff[read_addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

`default_nettype wire

// File: src/lap5n_ctrl.sv
// Position tracking: input and result raster counters, edge flags, drop decisions.
// Depends on lap5n_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lap5n_ctrl #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic [lap5n_pkg::CFG_SIZE_W-1:0]      grid_width,
   input  wire logic [lap5n_pkg::CFG_SIZE_W-1:0]      grid_height,
   input  wire logic                                  size_clear,
   input  wire logic                                  accept,
   input  wire logic                                  op,
   output      logic                                  active,
   output      logic [$clog2(MAX_WIDTH)-1:0]          column,
   output      lap5n_pkg::point_flags_type            flags
);

   import lap5n_pkg::*;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int WEFF_W = $clog2(MAX_WIDTH + 1);
   localparam int HEFF_W = $clog2(MAX_HEIGHT + 1);
   localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);   // input row runs to height+1 while draining
   localparam int OROW_W = $clog2(MAX_HEIGHT);

   logic [COL_W-1:0]  in_col_ff,  in_col_in;
   logic [ROW_W-1:0]  in_row_ff,  in_row_in;
   logic [COL_W-1:0]  out_col_ff, out_col_in;
   logic [OROW_W-1:0] out_row_ff, out_row_in;

   logic [WEFF_W-1:0] eff_w;
   logic [HEFF_W-1:0] eff_h;
   logic [WEFF_W-1:0] in_col_inc;
   logic [WEFF_W-1:0] out_col_inc;
   logic              frame_done;
   logic              drain;
   logic              frame_end;

   // clamp sizes to [2, MAX]
   always_comb begin
      if (grid_width < CFG_SIZE_W'(GRID_MIN)) begin
         eff_w = WEFF_W'(GRID_MIN);
      end else if (32'(grid_width) > 32'(MAX_WIDTH)) begin
         eff_w = WEFF_W'(MAX_WIDTH);
      end else begin
         eff_w = WEFF_W'(grid_width);
      end
      if (grid_height < CFG_SIZE_W'(GRID_MIN)) begin
         eff_h = HEFF_W'(GRID_MIN);
      end else if (32'(grid_height) > 32'(MAX_HEIGHT)) begin
         eff_h = HEFF_W'(MAX_HEIGHT);
      end else begin
         eff_h = HEFF_W'(grid_height);
      end
   end

   assign drain      = (op == OP_DRAIN);
   assign frame_done = (in_row_ff >= ROW_W'(eff_h));
   // samples only while the grid fills, drain ticks only once it is full
   assign active     = drain ? frame_done : !frame_done;

   assign in_col_inc  = WEFF_W'(in_col_ff) + WEFF_W'(1);
   assign out_col_inc = WEFF_W'(out_col_ff) + WEFF_W'(1);

   always_comb begin
      flags.emit      = (in_row_ff > ROW_W'(1))
                        || ((in_row_ff == ROW_W'(1)) && (in_col_ff != '0));
      flags.col_first = (out_col_ff == '0);
      flags.col_last  = (WEFF_W'(out_col_ff) == (eff_w - WEFF_W'(1)));
      flags.row_first = (out_row_ff == '0);
      flags.row_last  = (HEFF_W'(out_row_ff) == (eff_h - HEFF_W'(1)));
   end

   assign frame_end = flags.col_last && flags.row_last;
   assign column    = in_col_ff;

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (size_clear) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end else if (accept && active) begin
         if (in_col_inc >= eff_w) begin
            in_col_in = '0;
            in_row_in = in_row_ff + ROW_W'(1);
         end else begin
            in_col_in = COL_W'(in_col_inc);
         end
         if (flags.emit) begin
            if (out_col_inc >= eff_w) begin
               out_col_in = '0;
               out_row_in = out_row_ff + OROW_W'(1);
            end else begin
               out_col_in = COL_W'(out_col_inc);
            end
            // last point of the grid: start over
            if (frame_end) begin
               in_col_in  = '0;
               in_row_in  = '0;
               out_col_in = '0;
               out_row_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

endmodule

`default_nettype wire

// File: src/lap5n_stencil.sv
// Line stores, 3x3 column window and edge mirroring; produces both second differences.
// Depends on lap5n_pkg and lap5n_ram.
`timescale 1ns / 1ps
`default_nettype none

module lap5n_stencil #(
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   in_valid,
   output      logic                                   in_ready,
   input  wire logic [$clog2(MAX_WIDTH)-1:0]           in_column,
   input  wire logic signed [lap5n_pkg::SAMPLE_W-1:0]  in_sample,
   input  wire lap5n_pkg::point_flags_type             in_flags,
   output      logic                                   out_valid,
   input  wire logic                                   out_ready,
   output      logic signed [lap5n_pkg::DIFF_W-1:0]    out_diff_x,
   output      logic signed [lap5n_pkg::DIFF_W-1:0]    out_diff_y,
   output      logic                                   out_frame_end
);

   import lap5n_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);

   // stage 1: transaction waiting for its line-store read
   logic                       valid1_ff;
   point_flags_type            flags1_ff;
   logic signed [SAMPLE_W-1:0] sample1_ff;
   logic [COL_W-1:0]           column1_ff;

   logic signed [SAMPLE_W-1:0] older_rd;   // two rows back at this column
   logic signed [SAMPLE_W-1:0] newer_rd;   // one row back at this column

   // column window: previous column (up/centre/down) and centre row two columns back
   logic signed [SAMPLE_W-1:0] win_up_ff;
   logic signed [SAMPLE_W-1:0] win_ctr_ff;
   logic signed [SAMPLE_W-1:0] win_dn_ff;
   logic signed [SAMPLE_W-1:0] win_left_ff;

   // stage 2: differences
   logic                     valid2_ff;
   logic signed [DIFF_W-1:0] diff_x_ff, diff_x_in;
   logic signed [DIFF_W-1:0] diff_y_ff, diff_y_in;
   logic                     frame_end_ff;

   logic load2;
   logic retire1;
   logic read_en;

   logic signed [SAMPLE_W-1:0] nb_left, nb_right, nb_up, nb_down;

   assign load2    = !valid2_ff || out_ready;
   assign in_ready = !valid1_ff || load2;
   assign retire1  = valid1_ff && load2;
   assign read_en  = in_valid && in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else if (in_ready) begin
         valid1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (read_en) begin
         flags1_ff  <= in_flags;
         sample1_ff <= in_sample;
         column1_ff <= in_column;
      end
   end

   // older <= newer, newer <= sample, written as the transaction leaves stage 1
   lap5n_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_WIDTH)
   ) u_row_older (
      .clock      (clock),
      .write_en   (retire1),
      .write_addr (column1_ff),
      .write_data (newer_rd),
      .read_en    (read_en),
      .read_addr  (in_column),
      .read_data  (older_rd)
   );

   lap5n_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_WIDTH)
   ) u_row_newer (
      .clock      (clock),
      .write_en   (retire1),
      .write_addr (column1_ff),
      .write_data (sample1_ff),
      .read_en    (read_en),
      .read_addr  (in_column),
      .read_data  (newer_rd)
   );

   always_ff @(posedge clock) begin
      if (retire1) begin
         win_up_ff   <= older_rd;
         win_ctr_ff  <= newer_rd;
         win_dn_ff   <= sample1_ff;
         win_left_ff <= win_ctr_ff;
      end
   end

   // Neumann edges: a missing neighbour takes the opposite one
   always_comb begin
      nb_left  = flags1_ff.col_first ? newer_rd : win_left_ff;
      nb_right = flags1_ff.col_last ? win_left_ff : newer_rd;
      nb_up    = flags1_ff.row_first ? win_dn_ff : win_up_ff;
      nb_down  = flags1_ff.row_last ? win_up_ff : win_dn_ff;
      diff_x_in = DIFF_W'(nb_left) + DIFF_W'(nb_right) - (DIFF_W'(win_ctr_ff) <<< 1);
      diff_y_in = DIFF_W'(nb_up) + DIFF_W'(nb_down) - (DIFF_W'(win_ctr_ff) <<< 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
      end else if (load2) begin
         valid2_ff <= valid1_ff && flags1_ff.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (retire1 && flags1_ff.emit) begin
         diff_x_ff    <= diff_x_in;
         diff_y_ff    <= diff_y_in;
         frame_end_ff <= flags1_ff.col_last && flags1_ff.row_last;
      end
   end

   assign out_valid     = valid2_ff;
   assign out_diff_x    = diff_x_ff;
   assign out_diff_y    = diff_y_ff;
   assign out_frame_end = frame_end_ff;

endmodule

`default_nettype wire

// File: src/lap5n_mac.sv
// Coefficient multiply, sum and Q16 floor shift, ending in the result register.
// Depends on lap5n_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lap5n_mac (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   in_valid,
   output      logic                                   in_ready,
   input  wire logic signed [lap5n_pkg::DIFF_W-1:0]    in_diff_x,
   input  wire logic signed [lap5n_pkg::DIFF_W-1:0]    in_diff_y,
   input  wire logic                                   in_frame_end,
   input  wire logic [lap5n_pkg::COEF_W-1:0]           coef_x,
   input  wire logic [lap5n_pkg::COEF_W-1:0]           coef_y,
   output      logic                                   rsp_valid,
   input  wire logic                                   rsp_stall,
   output      logic signed [lap5n_pkg::RESULT_W-1:0]  rsp_laplacian,
   output      logic                                   rsp_frame_end
);

   import lap5n_pkg::*;

   logic signed [COEF_W:0]   coef_x_s;
   logic signed [COEF_W:0]   coef_y_s;
   logic signed [PROD_W-1:0] prod_x_in, prod_y_in;
   logic signed [SUM_W-1:0]  sum;

   // stage 3: products
   logic                     valid3_ff;
   logic signed [PROD_W-1:0] prod_x_ff, prod_y_ff;
   logic                     frame_end3_ff;

   // result register
   logic                       rsp_valid_ff;
   logic signed [RESULT_W-1:0] laplacian_ff;
   logic                       frame_end_ff;

   logic load3;
   logic load4;

   assign load4    = !rsp_valid_ff || !rsp_stall;
   assign load3    = !valid3_ff || load4;
   assign in_ready = load3;

   assign coef_x_s  = {1'b0, coef_x};
   assign coef_y_s  = {1'b0, coef_y};
   assign prod_x_in = PROD_W'(in_diff_x) * PROD_W'(coef_x_s);
   assign prod_y_in = PROD_W'(in_diff_y) * PROD_W'(coef_y_s);

   // arithmetic right shift by 16 is just the upper bits of the sum
   assign sum = SUM_W'(prod_x_ff) + SUM_W'(prod_y_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid3_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load3) begin
            valid3_ff <= in_valid;
         end
         if (load4) begin
            rsp_valid_ff <= valid3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && load3) begin
         prod_x_ff     <= prod_x_in;
         prod_y_ff     <= prod_y_in;
         frame_end3_ff <= in_frame_end;
      end
      if (valid3_ff && load4) begin
         laplacian_ff <= sum[SUM_W-1:FRAC_BITS];
         frame_end_ff <= frame_end3_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_laplacian = laplacian_ff;
   assign rsp_frame_end = frame_end_ff;

endmodule

`default_nettype wire

// File: src/laplacian_5point_neumann_stream_core.sv
// Five-point Laplacian over a raster stream, mirrored edges; top level.
// A result passes stages 1 to 3 and the result register once the transaction completing it
// is accepted; a grid point completes W+1 transactions after its own sample (W = grid width).
// Throughput: one request transaction per cycle unless stalled; stalls ride through a 4-stage pipeline.
// Reset is synchronous: counters and valids clear, sizes 64x64, coefficients 1.0 (Q16.16).
// The two line stores are not cleared; entries are always written before they are used.
// Depends on lap5n_pkg, lap5n_ctrl, lap5n_stencil, lap5n_mac and lap5n_ram.
`timescale 1ns / 1ps
`default_nettype none

module laplacian_5point_neumann_stream_core #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // request channel
   input  wire logic                                   req_valid,
   output      logic                                   req_stall,
   input  wire logic                                   req_op,
   input  wire logic signed [lap5n_pkg::SAMPLE_W-1:0]  req_sample,
   // result channel
   output      logic                                   rsp_valid,
   input  wire logic                                   rsp_stall,
   output      logic signed [lap5n_pkg::RESULT_W-1:0]  rsp_laplacian,
   output      logic                                   rsp_frame_end,
   // configuration
   input  wire logic                                   csr_write_en,
   input  wire logic [lap5n_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [lap5n_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   import lap5n_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);

   // configuration registers
   logic [CFG_SIZE_W-1:0] grid_width_ff,  grid_width_in;
   logic [CFG_SIZE_W-1:0] grid_height_ff, grid_height_in;
   logic [COEF_W-1:0]     coef_x_ff,      coef_x_in;
   logic [COEF_W-1:0]     coef_y_ff,      coef_y_in;
   logic                  size_clear;

   logic                       accept;
   logic                       active;
   logic [COL_W-1:0]           column;
   point_flags_type            flags;
   logic signed [SAMPLE_W-1:0] stencil_sample;
   logic                       stencil_ready;

   logic                     diff_valid;
   logic                     mac_ready;
   logic signed [DIFF_W-1:0] diff_x, diff_y;
   logic                     diff_frame_end;

   // ---------------------------------------------------------------------
   // Configuration. Writing either size abandons the grid in progress, so the
   // position counters go back to the origin.
   // ---------------------------------------------------------------------
   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      coef_x_in      = coef_x_ff;
      coef_y_in      = coef_y_ff;
      size_clear     = 1'b0;
      if (csr_write_en) begin
         case (csr_index)
            CSR_GRID_WIDTH: begin
               grid_width_in = csr_wdata[CFG_SIZE_W-1:0];
               size_clear    = 1'b1;
            end
            CSR_GRID_HEIGHT: begin
               grid_height_in = csr_wdata[CFG_SIZE_W-1:0];
               size_clear     = 1'b1;
            end
            CSR_COEF_X: begin
               coef_x_in = csr_wdata[COEF_W-1:0];
            end
            CSR_COEF_Y: begin
               coef_y_in = csr_wdata[COEF_W-1:0];
            end
            default: begin
               size_clear = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= GRID_SIZE_RESET;
         grid_height_ff <= GRID_SIZE_RESET;
         coef_x_ff      <= COEF_RESET;
         coef_y_ff      <= COEF_RESET;
      end else begin
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
         coef_x_ff      <= coef_x_in;
         coef_y_ff      <= coef_y_in;
      end
   end

   // ---------------------------------------------------------------------
   // Request side. Every transaction is taken when the first pipeline stage
   // has room; ones that change nothing (early drain, samples past the end of
   // the grid) are simply dropped and never enter the pipeline.
   // ---------------------------------------------------------------------
   assign req_stall = !stencil_ready;
   assign accept    = req_valid && stencil_ready;

   lap5n_ctrl #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .grid_width  (grid_width_ff),
      .grid_height (grid_height_ff),
      .size_clear  (size_clear),
      .accept      (accept),
      .op          (req_op),
      .active      (active),
      .column      (column),
      .flags       (flags)
   );

   // drain ticks shift zeros into the line stores
   assign stencil_sample = (req_op == OP_DRAIN) ? '0 : req_sample;

   // ---------------------------------------------------------------------
   // Stage 1: line-store read at the input column; the window of the last
   // two columns plus the fresh read gives all five taps of the point one row
   // and one column behind. Stage 2 holds the two second differences.
   // ---------------------------------------------------------------------
   lap5n_stencil #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_stencil (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (accept && active),
      .in_ready      (stencil_ready),
      .in_column     (column),
      .in_sample     (stencil_sample),
      .in_flags      (flags),
      .out_valid     (diff_valid),
      .out_ready     (mac_ready),
      .out_diff_x    (diff_x),
      .out_diff_y    (diff_y),
      .out_frame_end (diff_frame_end)
   );

   // ---------------------------------------------------------------------
   // Stage 3: two 26x33 multiplies, registered. Stage 4: sum, floor shift by
   // 16 and the result register that faces the rsp channel.
   // ---------------------------------------------------------------------
   lap5n_mac u_mac (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (diff_valid),
      .in_ready      (mac_ready),
      .in_diff_x     (diff_x),
      .in_diff_y     (diff_y),
      .in_frame_end  (diff_frame_end),
      .coef_x        (coef_x_ff),
      .coef_y        (coef_y_ff),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_laplacian (rsp_laplacian),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

`default_nettype wire
